@@ rtl/core/pfm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM frequency multiplier package
// Shared constants for the PWM frequency multiplier: counter limits, reset
// values and the default output divider.
// ----------------------------------------------------------------------------
package pfm_pkg;

   // Width of the tick counter bytes and of the output top and compare values.
   localparam int unsigned ByteWidth = 8;

   // Width of the change threshold register and of the measured times.
   localparam int unsigned MeasureWidth = 16;

   // Highest value the high byte of the tick counter may reach before timeout.
   localparam logic [ByteWidth-1:0] HighLimit = 8'd254;

   // Default number of ticks per output counter step.
   localparam int unsigned OutputDividerDefault = 2;

   // Reset values.
   localparam logic [MeasureWidth-1:0] ThresholdReset = 16'd111;
   localparam logic [ByteWidth-1:0]    TopReset       = 8'd255;

endpackage

@@ rtl/core/pwm_frequency_multiplier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM frequency multiplier
// Measures a slow PWM input tick by tick and regenerates it at a higher
// frequency from a free running output counter.
// ----------------------------------------------------------------------------
// Each input beat is one base tick carrying the input level, and it yields one
// result beat. A beat is captured in an input register and, when it moves on,
// one pass of short logic updates the tick counter, the period and on-time
// measurements, the output top and compare values and the output counter, and
// writes the result register. The block takes one beat every clock cycle
// while the result side does not stall. The result register decouples
// the two sides, so a stalled result holds only the input stage, and input
// stall rises only when the input register is full and cannot move on.
// change_threshold may be written only while no beat is in flight.
// ----------------------------------------------------------------------------
module pwm_frequency_multiplier #(
   parameter int unsigned OUTPUT_DIVIDER = pfm_pkg::OutputDividerDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_pin_level,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_pwm_out,
   output logic [pfm_pkg::ByteWidth-1:0]       rsp_period_top,
   output logic [pfm_pkg::ByteWidth-1:0]       rsp_duty_compare,
   output logic                                rsp_timed_out,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfm_pkg::MeasureWidth-1:0]    csr_data
);

   localparam int unsigned PhaseWidth = (OUTPUT_DIVIDER > 1) ? $clog2(OUTPUT_DIVIDER) : 1;
   localparam logic [PhaseWidth-1:0] PhaseLast = PhaseWidth'(OUTPUT_DIVIDER - 1);

   // Configuration register.
   logic [pfm_pkg::MeasureWidth-1:0] threshold_ff;

   // Input stage.
   logic s1_valid_ff;
   logic s1_level_ff;
   logic advance;

   // Block state.
   logic [pfm_pkg::ByteWidth-1:0]    low_count_ff,      low_count_in;
   logic [pfm_pkg::ByteWidth-1:0]    high_count_ff,     high_count_in;
   logic                             last_level_ff;
   logic [pfm_pkg::MeasureWidth-1:0] period_measure_ff, period_measure_in;
   logic [pfm_pkg::MeasureWidth-1:0] ontime_measure_ff, ontime_measure_in;
   logic [pfm_pkg::ByteWidth-1:0]    top_value_ff,      top_value_in;
   logic [pfm_pkg::ByteWidth-1:0]    compare_value_ff,  compare_value_in;
   logic [pfm_pkg::ByteWidth-1:0]    out_count_ff,      out_count_in;
   logic [PhaseWidth-1:0]            divider_phase_ff,  divider_phase_in;
   logic                             timeout_in;

   // Result register.
   logic                          rsp_valid_ff;
   logic                          rsp_pwm_out_ff;
   logic [pfm_pkg::ByteWidth-1:0] rsp_period_top_ff;
   logic [pfm_pkg::ByteWidth-1:0] rsp_duty_compare_ff;
   logic                          rsp_timed_out_ff;

   // Measurement compare helpers.
   logic [pfm_pkg::MeasureWidth-1:0] measured;
   logic [pfm_pkg::MeasureWidth-1:0] period_diff;
   logic [pfm_pkg::MeasureWidth-1:0] ontime_diff;
   logic                             rising;
   logic                             falling;

   // The input stage moves on when the result register is free or being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign csr_ready = 1'b1;

   // Configuration register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= pfm_pkg::ThresholdReset;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_level_ff <= req_pin_level;
      end
   end

   // Edge detection and the distance of the measured time from the stored ones.
   assign measured = {high_count_ff, low_count_ff};
   assign rising   = s1_level_ff && !last_level_ff;
   assign falling  = !s1_level_ff && last_level_ff;
   assign period_diff = (measured > period_measure_ff) ? (measured - period_measure_ff)
                                                       : (period_measure_ff - measured);
   assign ontime_diff = (measured > ontime_measure_ff) ? (measured - ontime_measure_ff)
                                                       : (ontime_measure_ff - measured);

   // Next state for one tick.
   always_comb begin
      low_count_in      = low_count_ff;
      high_count_in     = high_count_ff;
      period_measure_in = period_measure_ff;
      ontime_measure_in = ontime_measure_ff;
      top_value_in      = top_value_ff;
      compare_value_in  = compare_value_ff;
      timeout_in        = 1'b0;

      if (rising) begin
         // A rising edge closes a period and restarts the tick counter.
         if (period_diff > threshold_ff) begin
            period_measure_in = measured;
            top_value_in      = high_count_ff;
         end
         low_count_in  = '0;
         high_count_in = '0;
      end else begin
         // A falling edge closes the on-time.
         if (falling && (ontime_diff > threshold_ff)) begin
            ontime_measure_in = measured;
            compare_value_in  = high_count_ff;
         end
         low_count_in = low_count_ff + 1'b1;
         if (low_count_ff == '1) begin
            if (high_count_ff < pfm_pkg::HighLimit) begin
               high_count_in = high_count_ff + 1'b1;
            end else begin
               // No rising edge for too long: top goes to the limit, compare follows the input level.
               compare_value_in  = s1_level_ff ? pfm_pkg::HighLimit : '0;
               top_value_in      = pfm_pkg::HighLimit;
               high_count_in     = '0;
               period_measure_in = '0;
               ontime_measure_in = '0;
               timeout_in        = 1'b1;
            end
         end
      end
   end

   // Output counter, stepped once every OUTPUT_DIVIDER ticks.
   always_comb begin
      divider_phase_in = divider_phase_ff + 1'b1;
      out_count_in     = out_count_ff;
      if (divider_phase_ff >= PhaseLast) begin
         divider_phase_in = '0;
         if (out_count_ff >= top_value_in) begin
            out_count_in = '0;
         end else begin
            out_count_in = out_count_ff + 1'b1;
         end
      end
   end

   // State update on each tick that leaves the input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_count_ff      <= '0;
         high_count_ff     <= '0;
         last_level_ff     <= 1'b0;
         period_measure_ff <= '0;
         ontime_measure_ff <= '0;
         top_value_ff      <= pfm_pkg::TopReset;
         compare_value_ff  <= '0;
         out_count_ff      <= '0;
         divider_phase_ff  <= '0;
      end else if (s1_valid_ff && advance) begin
         low_count_ff      <= low_count_in;
         high_count_ff     <= high_count_in;
         last_level_ff     <= s1_level_ff;
         period_measure_ff <= period_measure_in;
         ontime_measure_ff <= ontime_measure_in;
         top_value_ff      <= top_value_in;
         compare_value_ff  <= compare_value_in;
         out_count_ff      <= out_count_in;
         divider_phase_ff  <= divider_phase_in;
      end
   end

   // Result register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         rsp_pwm_out_ff      <= (out_count_in < compare_value_in);
         rsp_period_top_ff   <= top_value_in;
         rsp_duty_compare_ff <= compare_value_in;
         rsp_timed_out_ff    <= timeout_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pwm_out      = rsp_pwm_out_ff;
   assign rsp_period_top   = rsp_period_top_ff;
   assign rsp_duty_compare = rsp_duty_compare_ff;
   assign rsp_timed_out    = rsp_timed_out_ff;

`ifndef SYNTHESIS
   // A timeout beat reports the limit as top and the limit or zero as compare.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_timed_out_ff) |->
      (rsp_period_top_ff == pfm_pkg::HighLimit &&
       (rsp_duty_compare_ff == pfm_pkg::HighLimit || rsp_duty_compare_ff == '0)))
      else $error("timeout beat carries wrong top or compare");

   // The high byte of the tick counter never passes the limit.
   assert property (@(posedge clock) disable iff (reset)
      high_count_ff <= pfm_pkg::HighLimit)
      else $error("tick counter high byte above limit");

   // The divider phase stays inside its range.
   assert property (@(posedge clock) disable iff (reset)
      divider_phase_ff <= PhaseLast)
      else $error("divider phase out of range");

   // State changes only when a tick leaves the input stage.
   assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && advance) |=> $stable(low_count_ff) && $stable(out_count_ff))
      else $error("state changed without a tick");
`endif

endmodule

@@ verif/pwm_frequency_multiplier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM frequency multiplier testbench
// Drives tick beats carrying the input level into the block, predicts every
// result beat with a behavioral copy of the measurement and output counters,
// and compares each result beat field by field. Covers the first edge after
// reset, threshold extremes, a period long enough to move the high byte,
// long output back-pressure and random waveforms.
// ----------------------------------------------------------------------------
module pwm_frequency_multiplier_tb;

   localparam int unsigned PipeLatency   = 2;
   localparam int unsigned OutputDivider = pfm_pkg::OutputDividerDefault;
   localparam int unsigned CycleLimit    = 50_000;

   // One expected result beat.
   typedef struct packed {
      logic                          pwm_out;
      logic [pfm_pkg::ByteWidth-1:0] period_top;
      logic [pfm_pkg::ByteWidth-1:0] duty_compare;
      logic                          timed_out;
   } pwm_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_pin_level = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_pwm_out;
   logic [pfm_pkg::ByteWidth-1:0]    rsp_period_top;
   logic [pfm_pkg::ByteWidth-1:0]    rsp_duty_compare;
   logic                             rsp_timed_out;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [pfm_pkg::MeasureWidth-1:0] csr_data = '0;

   // Predicted block state.
   logic [pfm_pkg::MeasureWidth-1:0] threshold    = pfm_pkg::ThresholdReset;
   logic [pfm_pkg::ByteWidth-1:0]    tick_lo      = '0;
   logic [pfm_pkg::ByteWidth-1:0]    tick_hi      = '0;
   logic                             prev_level   = 1'b0;
   logic [pfm_pkg::MeasureWidth-1:0] period_ticks = '0;
   logic [pfm_pkg::MeasureWidth-1:0] ontime_ticks = '0;
   logic [pfm_pkg::ByteWidth-1:0]    top_val      = pfm_pkg::TopReset;
   logic [pfm_pkg::ByteWidth-1:0]    cmp_val      = '0;
   logic [pfm_pkg::ByteWidth-1:0]    out_cnt      = '0;
   logic [3:0]                       div_phase    = '0;

   pwm_result_type expected_results[$];

   int  error_count   = 0;
   int  ticks_sent    = 0;
   int  cycle_count   = 0;
   bit  idle_on       = 1'b1;
   int  hold_request  = 0;
   int  hold_served   = 0;
   int  hold_left     = 0;
   int  burst_left    = 0;

   pwm_frequency_multiplier DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pwm_out      (rsp_pwm_out),
      .rsp_period_top   (rsp_period_top),
      .rsp_duty_compare (rsp_duty_compare),
      .rsp_timed_out    (rsp_timed_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // True when two measured times are further apart than the threshold.
   function automatic bit exceeds_threshold(input logic [pfm_pkg::MeasureWidth-1:0] a,
                                            input logic [pfm_pkg::MeasureWidth-1:0] b,
                                            input logic [pfm_pkg::MeasureWidth-1:0] limit);
      logic [pfm_pkg::MeasureWidth-1:0] diff;
      diff = (a > b) ? a - b : b - a;
      return diff > limit;
   endfunction

   // Advances the predicted state by one tick and queues the expected beat.
   function automatic void predict_tick(input logic level);
      logic [pfm_pkg::MeasureWidth-1:0] measured;
      logic                             rising;
      logic                             falling;
      logic                             timeout;
      pwm_result_type                   beat;
      measured = {tick_hi, tick_lo};
      rising   = level && !prev_level;
      falling  = !level && prev_level;
      timeout  = 1'b0;
      if (rising) begin
         if (exceeds_threshold(measured, period_ticks, threshold)) begin
            period_ticks = measured;
            top_val      = tick_hi;
         end
         tick_lo = '0;
         tick_hi = '0;
      end else begin
         if (falling && exceeds_threshold(measured, ontime_ticks, threshold)) begin
            ontime_ticks = measured;
            cmp_val      = tick_hi;
         end
         tick_lo = tick_lo + 8'd1;
         if (tick_lo == '0) begin
            if (tick_hi < pfm_pkg::HighLimit) begin
               tick_hi = tick_hi + 8'd1;
            end else begin
               // No rising edge up to the high byte limit: top goes to the limit, compare follows the level.
               cmp_val      = level ? pfm_pkg::HighLimit : '0;
               top_val      = pfm_pkg::HighLimit;
               tick_hi      = '0;
               period_ticks = '0;
               ontime_ticks = '0;
               timeout      = 1'b1;
            end
         end
      end
      prev_level = level;

      // Output counter steps once every OutputDivider ticks, wrapping at top.
      if (int'(div_phase) + 1 >= int'(OutputDivider)) begin
         div_phase = '0;
         out_cnt   = (out_cnt >= top_val) ? '0 : out_cnt + 8'd1;
      end else begin
         div_phase = div_phase + 4'd1;
      end

      beat.pwm_out      = out_cnt < cmp_val;
      beat.period_top   = top_val;
      beat.duty_compare = cmp_val;
      beat.timed_out    = timeout;
      expected_results.push_back(beat);
   endfunction

   // Watches accepted register writes and tick beats.
   always @(posedge clock) begin
      if (reset) begin
         threshold    = pfm_pkg::ThresholdReset;
         tick_lo      = '0;
         tick_hi      = '0;
         prev_level   = 1'b0;
         period_ticks = '0;
         ontime_ticks = '0;
         top_val      = pfm_pkg::TopReset;
         cmp_val      = '0;
         out_cnt      = '0;
         div_phase    = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            threshold = csr_data;
         end
         if (req_valid && !req_stall) begin
            predict_tick(req_pin_level);
         end
      end
   end

   // Compares each accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      pwm_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result beat with no prediction pending");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_pwm_out !== want.pwm_out) begin
               $error("pwm_out mismatch: expected %0d, actual %0d",
                      want.pwm_out, rsp_pwm_out);
               error_count++;
            end
            if (rsp_period_top !== want.period_top) begin
               $error("period_top mismatch: expected %0d, actual %0d",
                      want.period_top, rsp_period_top);
               error_count++;
            end
            if (rsp_duty_compare !== want.duty_compare) begin
               $error("duty_compare mismatch: expected %0d, actual %0d",
                      want.duty_compare, rsp_duty_compare);
               error_count++;
            end
            if (rsp_timed_out !== want.timed_out) begin
               $error("timed_out mismatch: expected %0d, actual %0d",
                      want.timed_out, rsp_timed_out);
               error_count++;
            end
         end
      end
   end

   // Result side stall: random short bursts, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request != hold_served) begin
         hold_served = hold_request;
         hold_left   = int'($urandom_range(40, 80));
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         rsp_stall <= 1'b1;
         burst_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         burst_left = int'($urandom_range(0, 3));
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Sends one tick beat, sometimes after a short idle gap.
   task automatic send_tick(input logic level);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = int'($urandom_range(1, 4));
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pin_level <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic send_run(input logic level, input int count);
      repeat (count) send_tick(level);
   endtask

   // Whole PWM periods with random period and high time.
   task automatic pwm_waveform(input int periods, input int min_len, input int max_len);
      int len;
      int high_len;
      repeat (periods) begin
         len      = int'($urandom_range(min_len, max_len));
         high_len = int'($urandom_range(1, len - 1));
         send_run(1'b1, high_len);
         send_run(1'b0, len - high_len);
      end
   endtask

   // Mostly well-formed short periods, with bursts of random levels between.
   task automatic random_mix(input int count);
      int start;
      int len;
      int high_len;
      start = ticks_sent;
      while (ticks_sent - start < count) begin
         if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
         end else begin
            len      = int'($urandom_range(2, 24));
            high_len = int'($urandom_range(1, len - 1));
            send_run(1'b1, high_len);
            send_run(1'b0, len - high_len);
         end
      end
   endtask

   // Stops sending and waits until every predicted beat has come back.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (PipeLatency + 2) @(posedge clock);
   endtask

   // Writes the change threshold once the block is idle.
   task automatic write_threshold(input logic [pfm_pkg::MeasureWidth-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // First tick high counts as a rising edge, then a few short edges.
   task automatic test_edges_after_reset;
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_run(1'b1, 4);
      send_run(1'b0, 6);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // Every measured change updates period and on-time.
   task automatic test_threshold_zero;
      write_threshold('0);
      pwm_waveform(3, 4, 16);
      random_mix(20);
   endtask

   // No measured change can pass the largest threshold.
   task automatic test_threshold_max;
      write_threshold('1);
      pwm_waveform(2, 4, 16);
   endtask

   // One period longer than the low byte range, so the high byte becomes top.
   task automatic test_long_period;
      write_threshold(16'd40);
      pwm_waveform(1, 258, 270);
      send_run(1'b1, 2);
   endtask

   // Long result hold-off while ticks keep coming, so the input backs up.
   task automatic test_output_backpressure;
      write_threshold(16'd40);
      hold_request++;
      send_run(1'b1, 10);
      send_run(1'b0, 12);
   endtask

   // Random threshold values and random waveforms.
   task automatic test_random_ticks;
      write_threshold(16'($urandom_range(0, 65535)));
      pwm_waveform(1, 4, 16);
      write_threshold(16'($urandom_range(0, 400)));
      random_mix(30);
   endtask

   // Last stretch with no idling on either side.
   task automatic test_quiet_finish;
      idle_on = 1'b0;
      write_threshold(16'd1);
      pwm_waveform(2, 4, 20);
      write_threshold(pfm_pkg::ThresholdReset);
      random_mix(20);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges_after_reset();
      test_threshold_zero();
      test_threshold_max();
      test_long_period();
      test_output_backpressure();
      test_random_ticks();
      test_quiet_finish();
      drain();
      if (expected_results.size() != 0) begin
         $error("%0d predicted result beats never arrived", expected_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
